// File: rtl/core/rgb_contrast_stretch_assert.svh
// Assertion macros for the contrast stretch block; clk and arst_n come from the user's scope.
`ifndef RGB_CONTRAST_STRETCH_ASSERT_SVH
`define RGB_CONTRAST_STRETCH_ASSERT_SVH

// same-cycle implication
`define RCS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcs: same-cycle check failed");

// next-cycle implication
`define RCS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcs: check failed");

`endif

// File: rtl/core/rcs_pkg.sv
// Shared types and constants for the RGB contrast stretch block.
package rcs_pkg;

	localparam int NumChan  = 3;
	localparam int ChanW    = 8;
	// one cell per quotient bit
	localparam int NumCells = ChanW;
	// front register plus the cells
	localparam int MaxPend  = NumCells + 1;

	localparam logic [ChanW-1:0] FullScale = 8'd255;
	localparam logic [ChanW-1:0] LowReset  = 8'd255;
	localparam logic [ChanW-1:0] HighReset = 8'd0;

	typedef enum logic {
		MODE_GATHER  = 1'b0,
		MODE_STRETCH = 1'b1
	} mode_t;

	// one channel's division state as it moves down the chain
	typedef struct packed {
		logic [ChanW-1:0] rem;
		logic [ChanW-1:0] work;
		logic [ChanW-1:0] span;
		logic             byp;
		logic [ChanW-1:0] byp_val;
	} lane_t;

	typedef lane_t [NumChan-1:0] pix_t;

endpackage

// File: rtl/core/rcs_front.sv
// Statistics registers and division setup for the RGB contrast stretch block.
module rcs_front
	import rcs_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_mode,
	input  logic                        in_first,
	input  logic [NumChan-1:0][ChanW-1:0] in_pix,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pix_t                        out_lanes
);

	logic [ChanW-1:0]   low_q  [NumChan];
	logic [ChanW-1:0]   high_q [NumChan];
	logic               valid_q;
	pix_t               lanes_q;
	pix_t               lanes_d;
	logic [ChanW-1:0]   diff   [NumChan];
	logic [2*ChanW-1:0] num    [NumChan];
	logic               accept;
	logic               is_stretch;

	assign in_ready   = !valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign is_stretch = (mode_t'(in_mode) == MODE_STRETCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NumChan; c++) begin
				low_q[c]  <= LowReset;
				high_q[c] <= HighReset;
			end
		end else if (accept && !is_stretch) begin
			for (int c = 0; c < NumChan; c++) begin
				if (in_first) begin
					low_q[c]  <= in_pix[c];
					high_q[c] <= in_pix[c];
				end else begin
					if (in_pix[c] < low_q[c])
						low_q[c] <= in_pix[c];
					if (in_pix[c] > high_q[c])
						high_q[c] <= in_pix[c];
				end
			end
		end
	end

	// numerator (v - low) * 255 as (d << 8) - d; its top byte is below span
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			diff[c] = in_pix[c] - low_q[c];
			num[c]  = {diff[c], {ChanW{1'b0}}} - {{ChanW{1'b0}}, diff[c]};
			lanes_d[c].rem  = num[c][2*ChanW-1:ChanW];
			lanes_d[c].work = num[c][ChanW-1:0];
			lanes_d[c].span = high_q[c] - low_q[c];
			if (high_q[c] <= low_q[c]) begin
				lanes_d[c].byp     = 1'b1;
				lanes_d[c].byp_val = in_pix[c];
			end else if (in_pix[c] <= low_q[c]) begin
				lanes_d[c].byp     = 1'b1;
				lanes_d[c].byp_val = '0;
			end else if (in_pix[c] >= high_q[c]) begin
				lanes_d[c].byp     = 1'b1;
				lanes_d[c].byp_val = FullScale;
			end else begin
				lanes_d[c].byp     = 1'b0;
				lanes_d[c].byp_val = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= accept && is_stretch;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_stretch)
			lanes_q <= lanes_d;
	end

	assign out_valid = valid_q;
	assign out_lanes = lanes_q;

endmodule

// File: rtl/core/rcs_cell.sv
// One restoring-division cell: resolves one quotient bit for all three channels.
module rcs_cell
	import rcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pix_t in_lanes,
	output logic out_valid,
	input  logic out_ready,
	output pix_t out_lanes
);

	logic             valid_q;
	pix_t             lanes_q;
	pix_t             lanes_d;
	logic [ChanW:0]   trial [NumChan];
	logic [ChanW:0]   diff  [NumChan];
	logic             ge    [NumChan];

	assign in_ready = !valid_q || out_ready;

	// bring down the next numerator bit, subtract span if it fits
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			trial[c] = {in_lanes[c].rem, in_lanes[c].work[ChanW-1]};
			diff[c]  = trial[c] - {1'b0, in_lanes[c].span};
			ge[c]    = (trial[c] >= {1'b0, in_lanes[c].span});
			lanes_d[c]         = in_lanes[c];
			lanes_d[c].rem     = ge[c] ? diff[c][ChanW-1:0] : trial[c][ChanW-1:0];
			lanes_d[c].work    = {in_lanes[c].work[ChanW-2:0], ge[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			lanes_q <= lanes_d;
	end

	assign out_valid = valid_q;
	assign out_lanes = lanes_q;

endmodule

// File: rtl/core/rgb_contrast_stretch.sv
// Per-channel min-max contrast stretch for RGB888 pixels, top level.
//
// Input stream s_axis: tdata = red, green, blue (8 bits each, red lowest);
// tuser[0] = mode (0 gather, 1 stretch), tuser[1] = first pixel of a gather pass.
// Output stream m_axis: tdata = stretched red, green, blue, red lowest.
// Gather items update the running min/max of each channel in the cycle they are
// accepted and give no output item. Stretch items give exactly one output item.
// One item is accepted per clock in both passes while s_axis_tready is high.
// A stretch item passes through 9 registers: one setup register computing
// (v-low)*255 and span, loaded at the accepting edge, then a chain of 8 division
// cells, each resolving one quotient bit.
// Each stage holds one item; when m_axis stalls, items pile up into empty
// stages and s_axis keeps accepting until the whole chain is full.
// Reset (arst_n low) empties the chain and sets every low to 255 and every
// high to 0, so channels pass through until a gather pass has run.
module rgb_contrast_stretch
	import rcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red_in[7:0], green_in[15:8], blue_in[23:16]
	input  logic [1:0]  s_axis_tuser,  // mode[0], first_pixel[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // red_out[7:0], green_out[15:8], blue_out[23:16]
);

	logic                          ch_valid [NumCells+1];
	logic                          ch_ready [NumCells+1];
	pix_t                          ch_lanes [NumCells+1];
	logic [NumChan-1:0][ChanW-1:0] pix_in;

	assign pix_in = s_axis_tdata;

	rcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser[0]),
		.in_first  (s_axis_tuser[1]),
		.in_pix    (pix_in),
		.out_valid (ch_valid[0]),
		.out_ready (ch_ready[0]),
		.out_lanes (ch_lanes[0])
	);

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		rcs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ch_valid[k]),
			.in_ready  (ch_ready[k]),
			.in_lanes  (ch_lanes[k]),
			.out_valid (ch_valid[k+1]),
			.out_ready (ch_ready[k+1]),
			.out_lanes (ch_lanes[k+1])
		);
	end

	assign m_axis_tvalid      = ch_valid[NumCells];
	assign ch_ready[NumCells] = m_axis_tready;

	// after the last cell, work holds the quotient
	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			m_axis_tdata[c*ChanW +: ChanW] = ch_lanes[NumCells][c].byp
				? ch_lanes[NumCells][c].byp_val : ch_lanes[NumCells][c].work;
		end
	end

endmodule

// File: rtl/core/rcs_checker.sv
// Port-level checks for the RGB contrast stretch block, bound to the top level.
`include "rgb_contrast_stretch_assert.svh"

module rcs_checker
	import rcs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	logic [3:0] pend_q;
	logic       in_stretch;
	logic       out_take;

	assign in_stretch = s_axis_tvalid && s_axis_tready
		&& (mode_t'(s_axis_tuser[0]) == MODE_STRETCH);
	assign out_take   = m_axis_tvalid && m_axis_tready;

	// stretch items in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {3'b0, in_stretch} - {3'b0, out_take};
		end
	end

	`RCS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`RCS_ASSERT_IMP(a_ready_when_free, !m_axis_tvalid || m_axis_tready, s_axis_tready)
	`RCS_ASSERT_IMP(a_no_invented, m_axis_tvalid, pend_q != 4'd0)
	`RCS_ASSERT_IMP(a_pend_bound, 1'b1, pend_q <= 4'(MaxPend))

endmodule

bind rgb_contrast_stretch rcs_checker u_rcs_checker (.*);
